// File: sv/lse_pkg.sv
`timescale 1ns / 1ps
// Package for the LIFO stack engine: command and status codes, controller
// states, and the command/status structs between controller and datapath.
// No dependencies.
package lse_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int WORD_WIDTH_DEF  = 64;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 6;
  localparam int PORT_W   = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FEW   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SWAP2,
    S_FINISH
  } state_t;

  // write data source
  typedef enum logic [1:0] {
    WSEL_VALUE,
    WSEL_RD1,
    WSEL_RD2,
    WSEL_ZERO
  } wsel_t;

  // write address: sp, sp-1, sp-2
  typedef enum logic [1:0] {
    ASEL_SP,
    ASEL_SP_M1,
    ASEL_SP_M2
  } asel_t;

  typedef enum logic [1:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC,
    SP_CLEAR
  } spop_t;

  typedef struct packed {
    logic                load_in;
    logic                rd_load;
    logic                wr_en;
    wsel_t               wr_sel;
    asel_t               wa_sel;
    spop_t               sp_op;
    logic                pend_load;
    logic                pend_data_rd;
    logic [STATUS_W-1:0] pend_status;
    logic                res_load;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             few;
    logic             out_busy;
  } dp_stat_t;

endpackage

// File: sv/lse_datapath.sv
`timescale 1ns / 1ps
// Datapath of the LIFO stack engine: entry memory, stack pointer, read
// registers and the output word register. Depends on lse_pkg.
module lse_datapath #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = lse_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lse_pkg::CMD_W-1:0]     cmd,
  input  logic [lse_pkg::PORT_W-1:0]    push_value,
  input  logic                          out_stall,
  input  lse_pkg::ctrl_t                ctrl,
  output lse_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [lse_pkg::PORT_W-1:0]    read_data,
  output logic [lse_pkg::STATUS_W-1:0]  status,
  output logic [lse_pkg::FILL_W-1:0]    fill_level
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

  logic [lse_pkg::CMD_W-1:0] cmd_q;
  logic [WORD_WIDTH-1:0]     value_q;
  logic [SPW-1:0]            sp;
  logic [SPW-1:0]            sp_next;
  logic [SPW-1:0]            sp_m1;
  logic [SPW-1:0]            sp_m2;
  logic [WORD_WIDTH-1:0]     rd1;
  logic [WORD_WIDTH-1:0]     rd2;
  logic [AW-1:0]             wr_addr;
  logic [WORD_WIDTH-1:0]     wr_data;

  logic                          pend_data_rd;
  logic [lse_pkg::STATUS_W-1:0]  pend_status;
  logic [WORD_WIDTH-1:0]         res_word;
  logic [WORD_WIDTH+lse_pkg::PORT_W-1:0] res_ext;
  logic [SPW+lse_pkg::FILL_W-1:0]        sp_ext;

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);

  always_comb begin
    case (ctrl.wa_sel)
      lse_pkg::ASEL_SP:    wr_addr = sp[AW-1:0];
      lse_pkg::ASEL_SP_M1: wr_addr = sp_m1[AW-1:0];
      lse_pkg::ASEL_SP_M2: wr_addr = sp_m2[AW-1:0];
      default:             wr_addr = sp[AW-1:0];
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      lse_pkg::WSEL_VALUE: wr_data = value_q;
      lse_pkg::WSEL_RD1:   wr_data = rd1;
      lse_pkg::WSEL_RD2:   wr_data = rd2;
      lse_pkg::WSEL_ZERO:  wr_data = '0;
      default:             wr_data = '0;
    endcase
  end

  always_comb begin
    case (ctrl.sp_op)
      lse_pkg::SP_HOLD:  sp_next = sp;
      lse_pkg::SP_INC:   sp_next = sp + SPW'(1);
      lse_pkg::SP_DEC:   sp_next = sp_m1;
      lse_pkg::SP_CLEAR: sp_next = '0;
      default:           sp_next = sp;
    endcase
  end

  // memory: one write port, two registered read ports at sp-1 and sp-2
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_load) begin
      rd1 <= mem[sp_m1[AW-1:0]];
      rd2 <= mem[sp_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_q   <= cmd;
      value_q <= push_value[WORD_WIDTH-1:0];
    end
    if (ctrl.pend_load) begin
      pend_data_rd <= ctrl.pend_data_rd;
      pend_status  <= ctrl.pend_status;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      res_word <= pend_data_rd ? rd1 : '0;
      status   <= pend_status;
      sp_ext   <= {{lse_pkg::FILL_W{1'b0}}, sp};
    end
  end

  assign res_ext    = {{lse_pkg::PORT_W{1'b0}}, res_word};
  assign read_data  = res_ext[lse_pkg::PORT_W-1:0];
  assign fill_level = sp_ext[lse_pkg::FILL_W-1:0];

  assign stat.cmd      = cmd_q;
  assign stat.empty    = (sp == '0);
  assign stat.full     = (sp >= SPW'(STACK_DEPTH));
  assign stat.few      = (sp < SPW'(2));
  assign stat.out_busy = out_valid && out_stall;

endmodule

// File: sv/lse_controller.sv
`timescale 1ns / 1ps
// Controller of the LIFO stack engine: sequences each command through
// read, execute and result steps. Depends on lse_pkg.
module lse_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lse_pkg::dp_stat_t  stat,
  output lse_pkg::ctrl_t     ctrl
);

  lse_pkg::state_t state;
  lse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lse_pkg::S_IDLE: begin
        if (in_valid) state_next = lse_pkg::S_READ;
      end
      lse_pkg::S_READ: state_next = lse_pkg::S_EXEC;
      lse_pkg::S_EXEC: begin
        if (stat.cmd == lse_pkg::CMD_SWAP && !stat.few) begin
          state_next = lse_pkg::S_SWAP2;
        end else begin
          state_next = lse_pkg::S_FINISH;
        end
      end
      lse_pkg::S_SWAP2: state_next = lse_pkg::S_FINISH;
      lse_pkg::S_FINISH: begin
        if (!stat.out_busy) state_next = lse_pkg::S_IDLE;
      end
      default: state_next = lse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl              = '0;
    ctrl.wr_sel       = lse_pkg::WSEL_VALUE;
    ctrl.wa_sel       = lse_pkg::ASEL_SP;
    ctrl.sp_op        = lse_pkg::SP_HOLD;
    ctrl.pend_status  = lse_pkg::ST_OK;
    in_stall          = 1'b1;
    case (state)
      lse_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        ctrl.load_in = in_valid;
      end
      lse_pkg::S_READ: begin
        ctrl.rd_load = 1'b1;
      end
      lse_pkg::S_EXEC: begin
        ctrl.pend_load = 1'b1;
        case (stat.cmd)
          lse_pkg::CMD_PUSH: begin
            if (stat.full) begin
              ctrl.pend_status = lse_pkg::ST_FULL;
            end else begin
              ctrl.wr_en = 1'b1;
              ctrl.sp_op = lse_pkg::SP_INC;
            end
          end
          lse_pkg::CMD_POP: begin
            if (stat.empty) begin
              ctrl.pend_status = lse_pkg::ST_EMPTY;
            end else begin
              ctrl.sp_op        = lse_pkg::SP_DEC;
              ctrl.pend_data_rd = 1'b1;
            end
          end
          lse_pkg::CMD_PEEK: begin
            if (stat.empty) begin
              ctrl.pend_status = lse_pkg::ST_EMPTY;
            end else begin
              ctrl.pend_data_rd = 1'b1;
            end
          end
          lse_pkg::CMD_DUP: begin
            // empty stack pushes a zero word but still reports empty
            if (stat.empty) begin
              ctrl.wr_en       = 1'b1;
              ctrl.wr_sel      = lse_pkg::WSEL_ZERO;
              ctrl.sp_op       = lse_pkg::SP_INC;
              ctrl.pend_status = lse_pkg::ST_EMPTY;
            end else if (stat.full) begin
              ctrl.pend_status = lse_pkg::ST_FULL;
            end else begin
              ctrl.wr_en  = 1'b1;
              ctrl.wr_sel = lse_pkg::WSEL_RD1;
              ctrl.sp_op  = lse_pkg::SP_INC;
            end
          end
          lse_pkg::CMD_SWAP: begin
            if (stat.few) begin
              ctrl.pend_status = lse_pkg::ST_FEW;
            end else begin
              ctrl.wr_en  = 1'b1;
              ctrl.wr_sel = lse_pkg::WSEL_RD2;
              ctrl.wa_sel = lse_pkg::ASEL_SP_M1;
            end
          end
          lse_pkg::CMD_CLEAR: begin
            ctrl.sp_op = lse_pkg::SP_CLEAR;
          end
          default: ;
        endcase
      end
      lse_pkg::S_SWAP2: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = lse_pkg::WSEL_RD1;
        ctrl.wa_sel = lse_pkg::ASEL_SP_M2;
      end
      lse_pkg::S_FINISH: begin
        ctrl.res_load = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/lifo_stack_engine.sv
`timescale 1ns / 1ps
// LIFO stack engine top level. Each accepted command runs through the read,
// execute and finish states of the controller; a swap adds a second write
// state, since it writes its two entries on the single write port. A new
// command is taken only after finish, and a stalled result waits in finish.
// Reset (rst, synchronous): depth zero, no result pending; entries undefined.
// Depends on lse_pkg, lse_controller, lse_datapath.
module lifo_stack_engine #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = lse_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lse_pkg::CMD_W-1:0]     cmd,
  input  logic [lse_pkg::PORT_W-1:0]    push_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lse_pkg::PORT_W-1:0]    read_data,
  output logic [lse_pkg::STATUS_W-1:0]  status,
  output logic [lse_pkg::FILL_W-1:0]    fill_level
);

  lse_pkg::ctrl_t    ctrl;
  lse_pkg::dp_stat_t stat;

  lse_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lse_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (push_value),
    .out_stall  (out_stall),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_valid  (out_valid),
    .read_data  (read_data),
    .status     (status),
    .fill_level (fill_level)
  );

endmodule

// File: sv/lse_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the LIFO stack engine, bound to the top level.
// Depends on lse_pkg.
module lse_checker #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lse_pkg::PORT_W-1:0]    read_data,
  input logic [lse_pkg::STATUS_W-1:0]  status,
  input logic [lse_pkg::FILL_W-1:0]    fill_level
);

  localparam int FULL_LVL_I = STACK_DEPTH % (1 << lse_pkg::FILL_W);
  localparam logic [lse_pkg::FILL_W-1:0] FULL_LVL = FULL_LVL_I[lse_pkg::FILL_W-1:0];

  // one word in flight: the input stalls right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // a full refusal leaves the stack at its full depth
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == lse_pkg::ST_FULL) |-> fill_level == FULL_LVL)
    else $error("full status with depth below capacity");

  // empty or too-few reports leave at most one entry, e.g. a duplicate's zero word
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == lse_pkg::ST_EMPTY || status == lse_pkg::ST_FEW))
      |-> fill_level < 2)
    else $error("empty or short status with depth of two or more");

  // refused commands never return data
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lse_pkg::ST_OK) |-> read_data == '0)
    else $error("nonzero read data with a refusal status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(read_data) && $stable(status) && $stable(fill_level)))
    else $error("stalled result changed");

endmodule

bind lifo_stack_engine lse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_lse_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .status     (status),
  .fill_level (fill_level)
);

// File: tb/lse_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the LIFO stack engine: tracks accepted commands on a
// stack model of its own and compares every result word. Depends on lse_pkg.
module lse_result_checker #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = lse_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lse_pkg::CMD_W-1:0]     cmd,
  input  logic [lse_pkg::PORT_W-1:0]    push_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lse_pkg::PORT_W-1:0]    read_data,
  input  logic [lse_pkg::STATUS_W-1:0]  status,
  input  logic [lse_pkg::FILL_W-1:0]    fill_level,
  output int                            mismatch_count,
  output int                            pending_count,
  output int                            results_checked,
  output int                            full_count,
  output int                            empty_count
);
  import lse_pkg::*;

  typedef struct packed {
    logic [PORT_W-1:0]   data;
    logic [STATUS_W-1:0] st;
    logic [FILL_W-1:0]   fill;
  } stack_result_t;

  localparam logic [PORT_W-1:0] WORD_MASK =
    (WORD_WIDTH >= PORT_W) ? {PORT_W{1'b1}} : ((64'd1 << WORD_WIDTH) - 64'd1);

  logic [PORT_W-1:0] stack_words [STACK_DEPTH];
  int unsigned       depth = 0;
  stack_result_t     expected_results [$];
  int                errors = 0;
  int                checked = 0;
  int                fulls = 0;
  int                empties = 0;

  // Applies one command to the model stack and returns the result word it gives.
  function automatic stack_result_t apply_stack_command(logic [CMD_W-1:0] c,
                                                        logic [PORT_W-1:0] v);
    stack_result_t     r;
    logic [PORT_W-1:0] held;
    r.data = '0;
    r.st   = ST_OK;
    case (c)
      CMD_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          stack_words[depth] = v & WORD_MASK;
          depth++;
        end
      end
      CMD_POP: begin
        if (depth == 0) begin
          r.st = ST_EMPTY;
        end else begin
          depth--;
          r.data = stack_words[depth];
        end
      end
      CMD_PEEK: begin
        if (depth == 0) r.st = ST_EMPTY;
        else r.data = stack_words[depth-1];
      end
      CMD_DUP: begin
        // empty stack: a zero word still goes on, but status says empty
        if (depth == 0) begin
          stack_words[0] = '0;
          depth = 1;
          r.st = ST_EMPTY;
        end else if (depth >= STACK_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          stack_words[depth] = stack_words[depth-1];
          depth++;
        end
      end
      CMD_SWAP: begin
        if (depth < 2) begin
          r.st = ST_FEW;
        end else begin
          held = stack_words[depth-1];
          stack_words[depth-1] = stack_words[depth-2];
          stack_words[depth-2] = held;
        end
      end
      CMD_CLEAR: depth = 0;
      default: ;
    endcase
    r.fill = FILL_W'(depth);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_stack_command(cmd, push_value));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result word: data %h status %0d fill %0d",
                     $realtime, read_data, status, fill_level);
          end
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.st == ST_FULL) fulls++;
          if (want.st == ST_EMPTY) empties++;
          if (read_data !== want.data || status !== want.st || fill_level !== want.fill) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result %0d mismatch: expected data %h status %0d fill %0d",
                       $realtime, checked, want.data, want.st, want.fill);
              $display("%0t:   got data %h status %0d fill %0d",
                       $realtime, read_data, status, fill_level);
            end
          end
        end
      end
    end
    mismatch_count  <= errors;
    pending_count   <= expected_results.size();
    results_checked <= checked;
    full_count      <= fulls;
    empty_count     <= empties;
  end

endmodule

// File: tb/tb_lifo_stack_engine.sv
`timescale 1ns / 1ps
// Testbench top for the LIFO stack engine: clock, reset, command stimulus,
// random stalls and the verdict. Depends on lse_pkg, lse_result_checker.
module tb_lifo_stack_engine;
  import lse_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

  localparam int RANDOM_WORDS = 1650;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd = CMD_PUSH;
  logic [PORT_W-1:0]   push_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PORT_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_level;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int full_count;
  int empty_count;
  int words_sent = 0;
  int cycle_count = 0;
  int in_quiet = 0;
  int out_quiet = 0;
  int hold_cycles = 0;

  lifo_stack_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .status     (status),
    .fill_level (fill_level)
  );

  lse_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .push_value      (push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .status          (status),
    .fill_level      (fill_level),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .full_count      (full_count),
    .empty_count     (empty_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
      $display("lifo_stack_engine regression: fail");
      $finish;
    end
  end

  // Wait cycles for one word; now and then a stretch of back-to-back words.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Result side: each result word is held off for a drawn number of valid cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      hold_cycles = draw_wait(out_quiet);
      out_stall <= (hold_cycles != 0);
    end else if (out_valid && hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= (hold_cycles != 0);
    end
  end

  // Valid stays high when the next word follows with no gap.
  task automatic issue_command(input logic [CMD_W-1:0] c, input logic [PORT_W-1:0] v);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    push_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [PORT_W-1:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return 64'd1 << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  // phase 0 grows the stack toward full, phase 1 drains it, phase 2 mixes
  function automatic logic [CMD_W-1:0] pick_command(int phase);
    int r;
    r = $urandom_range(0, 99);
    if (phase == 0) begin
      if (r < 60) return CMD_PUSH;
      if (r < 68) return CMD_DUP;
      if (r < 76) return CMD_SWAP;
      if (r < 84) return CMD_PEEK;
      if (r < 94) return CMD_POP;
      if (r < 99) return $urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO;
      return CMD_CLEAR;
    end
    if (phase == 1) begin
      if (r < 45) return CMD_POP;
      if (r < 55) return CMD_PEEK;
      if (r < 65) return CMD_SWAP;
      if (r < 80) return CMD_PUSH;
      if (r < 88) return CMD_DUP;
      if (r < 96) return $urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO;
      return CMD_CLEAR;
    end
    if (r < 30) return CMD_PUSH;
    if (r < 50) return CMD_POP;
    if (r < 62) return CMD_PEEK;
    if (r < 74) return CMD_DUP;
    if (r < 88) return CMD_SWAP;
    if (r < 97) return $urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO;
    return CMD_CLEAR;
  endfunction

  initial begin : stimulus
    int phase;
    int phase_left;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty-stack corners, dup of an empty stack, swap with one entry
    issue_command(CMD_POP, random_word());
    issue_command(CMD_PEEK, random_word());
    issue_command(CMD_SWAP, random_word());
    issue_command(CMD_DUP, random_word());
    issue_command(CMD_SWAP, random_word());
    issue_command(CMD_PEEK, random_word());
    issue_command(CMD_POP, random_word());
    // extreme words, swap, dup, unused codes, clear
    issue_command(CMD_PUSH, '1);
    issue_command(CMD_PUSH, '0);
    issue_command(CMD_PUSH, 64'h8000_0000_0000_0001);
    issue_command(CMD_PUSH, 64'h5555_5555_5555_5555);
    issue_command(CMD_SWAP, '1);
    issue_command(CMD_PEEK, '1);
    issue_command(CMD_DUP, '0);
    issue_command(CMD_POP, '1);
    issue_command(CMD_POP, '1);
    issue_command(CMD_NOP_LO, '1);
    issue_command(CMD_NOP_HI, random_word());
    issue_command(CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_command(CMD_CLEAR, '1);
    issue_command(CMD_POP, random_word());
    issue_command(CMD_PUSH, random_word());
    issue_command(CMD_DUP, random_word());
    issue_command(CMD_SWAP, random_word());
    issue_command(CMD_CLEAR, random_word());

    // start with a long grow phase so full is reached early
    phase      = 0;
    phase_left = 80;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      issue_command(pick_command(phase), random_word());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands, directed corners then grow/drain/mixed random phases.",
             words_sent);
    $display("Compared %0d results: %0d refused as full, %0d on an empty stack.",
             results_checked, full_count, empty_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("lifo_stack_engine regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
      $display("lifo_stack_engine regression: fail");
    end
    $finish;
  end

endmodule
